### rtl/wpm_pkg.sv
// Package for the wildcard pattern matcher: action codes, symbol constants,
// the per-cell control bundle and the default store depth. No dependencies.
package wpm_pkg;

  // Default number of pattern bytes held in the cell chain
  localparam int unsigned PatternMaxDefault = 32;

  // Pattern wildcards
  localparam logic [7:0] SymStar     = 8'd42;
  localparam logic [7:0] SymQuestion = 8'd63;

  // Transaction kinds on the input channel
  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_SUBJECT = 2'd1,
    ACT_EMPTY   = 2'd2
  } action_e;

  // Control broadcast from the top level to every cell
  typedef struct packed {
    logic       load;     // pattern byte accepted
    logic       new_pat;  // pattern byte starts a fresh pattern
    logic       step;     // subject byte that is not the last one
    logic       restart;  // subject ends: live set returns to the start set
    logic [7:0] sym;      // byte of the transaction
  } cell_ctrl_t;

endpackage

### rtl/wpm_item_if.sv
// Input channel of the wildcard pattern matcher: valid/ready plus one item.
// No dependencies.
interface wpm_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, output action, output symbol, output last, input ready);
  modport sink   (input valid, input action, input symbol, input last, output ready);
endinterface

### rtl/wpm_result_if.sv
// Result channel of the wildcard pattern matcher: valid/ready plus one result.
// No dependencies.
interface wpm_result_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, output matched, output pattern_overflow, input ready);
  modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

### rtl/wildcard_pattern_matcher_unit.sv
// Top level of the wildcard pattern matcher: control, end position, result register.
// Depends on wpm_pkg, wpm_item_if, wpm_result_if and wpm_cell.
//
//   channel | dir | modport | carries
//   in_i    | in  | sink    | action, symbol, last
//   out_o   | out | source  | matched, pattern_overflow
//
// One transaction per cycle unless the input is stalled; a result appears in the
// output register the cycle after the subject's last byte or the empty-subject
// item. The cell chain updates the live set; star closure ripples cell to cell.
// Reset clears the pattern to empty with only position zero live.
// Input is stalled only while a result waits and out_o.ready is low.
module wildcard_pattern_matcher_unit import wpm_pkg::*; #(
  parameter int unsigned PATTERN_MAX = PatternMaxDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  wpm_item_if.sink     in_i,
  wpm_result_if.source out_o
);

  localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);

  logic             loading_q, loading_d;
  logic [LEN_W-1:0] len_q, len_d, len_eff;
  logic             ovf_q, ovf_d;
  logic             full;
  logic             start_n_q, start_n_d, closed_n;
  logic             accept, produce, match;
  logic             out_valid_q, out_valid_d, matched_q, out_ovf_q;
  cell_ctrl_t       ctrl;

  logic [PATTERN_MAX:0] adv, prop, fwd;
  logic [PATTERN_MAX:0] start_vec, closed_vec;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign len_eff = loading_q ? '0 : len_q;
  assign full    = len_eff == LEN_W'(PATTERN_MAX);

  // Decode the transaction
  always_comb begin
    ctrl         = '0;
    ctrl.sym     = in_i.symbol;
    ctrl.new_pat = loading_q;
    produce      = 1'b0;
    loading_d    = loading_q;
    len_d        = len_q;
    ovf_d        = ovf_q;
    if (accept) begin
      case (in_i.action)
        ACT_LOAD: begin
          ctrl.load = 1'b1;
          loading_d = in_i.last;
          len_d     = full ? len_eff : len_eff + LEN_W'(1);
          ovf_d     = (loading_q ? 1'b0 : ovf_q) | full;
        end
        ACT_SUBJECT: begin
          loading_d    = 1'b1;
          ctrl.step    = !in_i.last;
          ctrl.restart = in_i.last;
          produce      = in_i.last;
        end
        ACT_EMPTY: begin
          loading_d    = 1'b1;
          ctrl.restart = 1'b1;
          produce      = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Cell chain, one cell per pattern byte
  assign adv[0]  = 1'b0;
  assign prop[0] = 1'b0;
  assign fwd[0]  = 1'b1;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    wpm_cell #(
      .IDX   (i),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .len_i       (len_q),
      .wr_idx_i    (len_eff),
      .adv_i       (adv[i]),
      .prop_i      (prop[i]),
      .start_fwd_i (fwd[i]),
      .adv_o       (adv[i+1]),
      .prop_o      (prop[i+1]),
      .start_fwd_o (fwd[i+1]),
      .closed_o    (closed_vec[i]),
      .start_o     (start_vec[i])
    );
  end

  // End position, past the last byte slot
  assign closed_n = adv[PATTERN_MAX] || prop[PATTERN_MAX];
  assign start_n_d = ctrl.load ? ((loading_q ? 1'b0 : start_n_q) | fwd[PATTERN_MAX])
                               : start_n_q;

  assign start_vec[PATTERN_MAX]  = start_n_q;
  assign closed_vec[PATTERN_MAX] = closed_n;

  // Pick the end-of-pattern bit; an empty subject is judged on the start set
  assign match = (in_i.action == ACT_EMPTY) ? start_vec[len_q] : closed_vec[len_q];

  assign out_valid_d = produce || (out_valid_q && !out_o.ready);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loading_q   <= 1'b1;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      start_n_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      loading_q   <= loading_d;
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      start_n_q   <= start_n_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    if (produce) begin
      matched_q <= match;
      out_ovf_q <= ovf_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.matched          = matched_q;
  assign out_o.pattern_overflow = out_ovf_q;

endmodule

### rtl/wpm_cell.sv
// One pattern position of the matcher chain: stored byte, live bit and start bit.
// Depends on wpm_pkg.
module wpm_cell import wpm_pkg::*; #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned LEN_W = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic [LEN_W-1:0] len_i,       // current pattern length
  input  logic [LEN_W-1:0] wr_idx_i,    // store slot for a pattern byte
  input  logic             adv_i,       // previous position advances into this one
  input  logic             prop_i,      // star closure from the previous position
  input  logic             start_fwd_i, // start bit handed on by a write upstream
  output logic             adv_o,
  output logic             prop_o,
  output logic             start_fwd_o,
  output logic             closed_o,    // closed next-live bit of this position
  output logic             start_o      // stored start bit
);

  logic [7:0] sym_q;
  logic       live_q, live_d;
  logic       start_q, start_d;
  logic       in_pat, wr, is_star, is_quest, hit, start_new, stay;

  assign in_pat   = LEN_W'(IDX) < len_i;
  assign wr       = ctrl_i.load && (wr_idx_i == LEN_W'(IDX));
  assign is_star  = sym_q == SymStar;
  assign is_quest = sym_q == SymQuestion;
  assign hit      = is_quest || (sym_q == ctrl_i.sym);

  // Start set: cleared by a fresh pattern, extended one slot past each star written at a start slot
  assign start_new   = (ctrl_i.new_pat ? 1'b0 : start_q) | start_fwd_i;
  assign start_fwd_o = wr && start_new && (ctrl_i.sym == SymStar);
  assign start_d     = ctrl_i.load ? start_new : start_q;

  // Subject step: a star keeps its position, a hit moves on, closure ripples
  assign stay     = live_q && in_pat && is_star;
  assign adv_o    = live_q && in_pat && !is_star && hit;
  assign closed_o = stay || adv_i || prop_i;
  assign prop_o   = closed_o && is_star && in_pat;

  // Next live bit
  always_comb begin
    live_d = live_q;
    if (ctrl_i.load) begin
      live_d = start_d;
    end else if (ctrl_i.restart) begin
      live_d = start_q;
    end else if (ctrl_i.step) begin
      live_d = closed_o;
    end
  end

  // Hold the pattern byte
  always_ff @(posedge clk_i) begin
    if (wr) begin
      sym_q <= ctrl_i.sym;
    end
  end

  // Live and start bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q  <= (IDX == 0);
      start_q <= (IDX == 0);
    end else begin
      live_q  <= live_d;
      start_q <= start_d;
    end
  end

  assign start_o = start_q;

endmodule
